// File: hw/rtl/tvfg_pkg.sv
// Shared widths, register codes and Taylor-series constants for the torus vertex generator.
package tvfg_pkg;

  localparam int MAX_DIVISIONS = 1024;

  localparam int IdxW  = 10;
  localparam int CntW  = 11;
  localparam int RadW  = 16;
  localparam int PosW  = 18;
  localparam int CornW = 20;
  localparam int TrigW = 18;  // signed Q16 sine/cosine, magnitude up to 1.0

  typedef enum logic [1:0] {
    REG_RING_COUNT = 2'd0,
    REG_SLICES     = 2'd1,
    REG_TUBE_RAD   = 2'd2,
    REG_MAIN_RAD   = 2'd3
  } reg_idx_e;

  // Angle divider: quotient bits resolved per stage.
  localparam int DivBits   = 4;
  localparam int DivStages = 32 / DivBits;

  localparam logic [30:0] Q30One = 31'h4000_0000;
  localparam logic [31:0] PiQ30  = 32'd3373259426;

  // Horner steps; sine uses slots 1..5, cosine all six.
  localparam int HornerSteps = 6;
  localparam int RcpShift    = 38;
  localparam int RcpW        = 38;
  localparam int RcpLoW      = 19;

  // Exact floor(m/d) for m < 2^30: R = floor(2^38/d)+1.
  localparam logic [RcpW-1:0] COS_RCP [HornerSteps] = '{
    RcpW'((64'd1 << RcpShift) / 64'd132 + 64'd1),
    RcpW'((64'd1 << RcpShift) / 64'd90 + 64'd1),
    RcpW'((64'd1 << RcpShift) / 64'd56 + 64'd1),
    RcpW'((64'd1 << RcpShift) / 64'd30 + 64'd1),
    RcpW'((64'd1 << RcpShift) / 64'd12 + 64'd1),
    RcpW'((64'd1 << RcpShift) / 64'd2 + 64'd1)
  };
  localparam logic [RcpW-1:0] SIN_RCP [HornerSteps] = '{
    RcpW'(0),
    RcpW'((64'd1 << RcpShift) / 64'd110 + 64'd1),
    RcpW'((64'd1 << RcpShift) / 64'd72 + 64'd1),
    RcpW'((64'd1 << RcpShift) / 64'd42 + 64'd1),
    RcpW'((64'd1 << RcpShift) / 64'd20 + 64'd1),
    RcpW'((64'd1 << RcpShift) / 64'd6 + 64'd1)
  };

  // divider, round, fold, angle, square, Horner, final product, quadrant
  localparam int ScLatency = DivStages + 4 + 3 * HornerSteps + 2;

endpackage

// File: hw/rtl/torus_vertex_and_face_generator.sv
// Top level: torus vertex and quad-face corner generator with APB register port.
// One word in per cycle while the output is not held, one word out per item. Two
// Taylor-series sine/cosine pipelines (32 stages each, led by a 4-bit-per-stage
// angle divider) and a 5-stage coordinate tail give 37 register stages, the first
// of which loads at the accepting edge.
// The whole pipeline freezes while the output word is held by out_stall_i, so
// in_stall_o follows out_stall_i whenever a word waits at the output.
module torus_vertex_and_face_generator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [3:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [tvfg_pkg::IdxW-1:0]          ring_index_i,
  input  logic [tvfg_pkg::IdxW-1:0]          slice_index_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [tvfg_pkg::PosW-1:0]   pos_x_o,
  output logic signed [tvfg_pkg::PosW-1:0]   pos_y_o,
  output logic signed [tvfg_pkg::PosW-1:0]   pos_z_o,
  output logic [tvfg_pkg::CornW-1:0]         corner_a_o,
  output logic [tvfg_pkg::CornW-1:0]         corner_b_o,
  output logic [tvfg_pkg::CornW-1:0]         corner_c_o,
  output logic [tvfg_pkg::CornW-1:0]         corner_d_o,
  output logic                               index_error_o
);

  localparam int CntW   = tvfg_pkg::CntW;
  localparam int IdxW   = tvfg_pkg::IdxW;
  localparam int RadW   = tvfg_pkg::RadW;
  localparam int PosW   = tvfg_pkg::PosW;
  localparam int CornW  = tvfg_pkg::CornW;
  localparam int TrigW  = tvfg_pkg::TrigW;
  localparam int Lat    = tvfg_pkg::ScLatency + 5;
  localparam int ProdW  = CntW + IdxW;

  typedef struct packed {
    logic             err;
    logic [CornW-1:0] ca;
    logic [CornW-1:0] cb;
    logic [CornW-1:0] cc;
    logic [CornW-1:0] cd;
  } side_t;

  // ---- configuration registers
  logic [CntW-1:0] ring_count_q, slices_q;
  logic [RadW-1:0] tube_q, main_q;
  tvfg_pkg::reg_idx_e wr_idx;

  assign wr_idx = tvfg_pkg::reg_idx_e'(paddr[3:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_count_q <= CntW'(16);
      slices_q     <= CntW'(16);
      tube_q       <= RadW'(256);
      main_q       <= RadW'(512);
    end else if (psel && penable && pwrite) begin
      unique case (wr_idx)
        tvfg_pkg::REG_RING_COUNT: ring_count_q <= pwdata[CntW-1:0];
        tvfg_pkg::REG_SLICES:     slices_q     <= pwdata[CntW-1:0];
        tvfg_pkg::REG_TUBE_RAD:   tube_q       <= pwdata[RadW-1:0];
        tvfg_pkg::REG_MAIN_RAD:   main_q       <= pwdata[RadW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (wr_idx)
      tvfg_pkg::REG_RING_COUNT: prdata = 32'(ring_count_q);
      tvfg_pkg::REG_SLICES:     prdata = 32'(slices_q);
      tvfg_pkg::REG_TUBE_RAD:   prdata = 32'(tube_q);
      tvfg_pkg::REG_MAIN_RAD:   prdata = 32'(main_q);
      default:                  prdata = '0;
    endcase
  end

  // effective counts, capped at the division limit
  logic [CntW-1:0] nr, ns;
  assign nr = (32'(ring_count_q) > 32'(tvfg_pkg::MAX_DIVISIONS)) ?
              CntW'(tvfg_pkg::MAX_DIVISIONS) : ring_count_q;
  assign ns = (32'(slices_q) > 32'(tvfg_pkg::MAX_DIVISIONS)) ?
              CntW'(tvfg_pkg::MAX_DIVISIONS) : slices_q;

  // ---- flow control: every stage advances unless the output word is held
  logic adv;
  logic v_q [Lat];

  assign adv         = !(v_q[Lat-1] && out_stall_i);
  assign in_stall_o  = !adv;
  assign out_valid_o = v_q[Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Lat; k++) begin
        v_q[k] <= 1'b0;
      end
    end else if (adv) begin
      v_q[0] <= in_valid_i;
      for (int k = 1; k < Lat; k++) begin
        v_q[k] <= v_q[k-1];
      end
    end
  end

  // ---- angle pipelines
  logic signed [TrigW-1:0] st, ct, sp, cp;

  tvfg_sincos u_theta (
    .clk_i (clk_i),
    .en_i  (adv),
    .idx_i (ring_index_i),
    .cnt_i (nr),
    .sin_o (st),
    .cos_o (ct)
  );

  tvfg_sincos u_phi (
    .clk_i (clk_i),
    .en_i  (adv),
    .idx_i (slice_index_i),
    .cnt_i (ns),
    .sin_o (sp),
    .cos_o (cp)
  );

  // ---- face corners: base product first, then the four sums
  logic             err0_q, wrap0_q;
  logic [ProdW-1:0] prod0_q;
  logic [IdxW-1:0]  si0_q;
  logic [CntW-1:0]  nsi0_q;
  logic [CntW-1:0]  si_inc;
  side_t            side_q [1:Lat-2];
  logic [ProdW:0]   nxt_base;

  assign si_inc   = CntW'(slice_index_i) + CntW'(1);
  assign nxt_base = {1'b0, prod0_q} + (ProdW+1)'(ns);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      err0_q  <= ({1'b0, ring_index_i} >= nr) || ({1'b0, slice_index_i} >= ns);
      wrap0_q <= (CntW'(ring_index_i) + CntW'(1)) == nr;
      prod0_q <= ProdW'(ring_index_i) * ProdW'(ns);
      si0_q   <= slice_index_i;
      nsi0_q  <= (si_inc == ns) ? '0 : si_inc;
      side_q[1].err <= err0_q;
      side_q[1].ca  <= CornW'(prod0_q + ProdW'(si0_q));
      side_q[1].cd  <= CornW'(prod0_q + ProdW'(nsi0_q));
      side_q[1].cb  <= wrap0_q ? CornW'(si0_q) : CornW'(nxt_base + (ProdW+1)'(si0_q));
      side_q[1].cc  <= wrap0_q ? CornW'(nsi0_q) : CornW'(nxt_base + (ProdW+1)'(nsi0_q));
      for (int k = 2; k <= Lat - 2; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // ---- vertex coordinates
  logic signed [34:0] inner_q, yp1_q, yp2_q, yp3_q;
  logic signed [TrigW-1:0] ct_q, nst_q;
  logic signed [35:0] xhi_q, xlo_q, zhi_q, zlo_q;
  logic signed [52:0] xs_q, zs_q;
  logic [51:0] xm_q, zm_q;
  logic [33:0] ym_q;
  logic        xn_q, yn_q, zn_q;

  logic signed [34:0] cpt;
  assign cpt = 35'(cp) * 35'($signed({1'b0, tube_q}));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      inner_q <= $signed({3'b0, main_q, 16'b0}) + cpt;
      yp1_q   <= 35'(sp) * 35'($signed({1'b0, tube_q}));
      ct_q    <= ct;
      nst_q   <= -st;
      xhi_q   <= 36'(ct_q) * 36'($signed(inner_q[34:17]));
      xlo_q   <= 36'(ct_q) * 36'($signed({1'b0, inner_q[16:0]}));
      zhi_q   <= 36'(nst_q) * 36'($signed(inner_q[34:17]));
      zlo_q   <= 36'(nst_q) * 36'($signed({1'b0, inner_q[16:0]}));
      yp2_q   <= yp1_q;
      xs_q    <= (53'(xhi_q) <<< 17) + 53'(xlo_q);
      zs_q    <= (53'(zhi_q) <<< 17) + 53'(zlo_q);
      yp3_q   <= yp2_q;
      xn_q    <= xs_q[52];
      zn_q    <= zs_q[52];
      yn_q    <= yp3_q[34];
      xm_q    <= xs_q[52] ? 52'(-xs_q) : 52'(xs_q);
      zm_q    <= zs_q[52] ? 52'(-zs_q) : 52'(zs_q);
      ym_q    <= yp3_q[34] ? 34'(-yp3_q) : 34'(yp3_q);
    end
  end

  // saturate a rounded magnitude to signed Q17.0
  function automatic logic signed [PosW-1:0] sat_pos(input logic neg, input logic [20:0] mr);
    if (neg) begin
      return (mr >= 21'd131072) ? 18'sh20000 : -$signed({1'b0, mr[PosW-2:0]});
    end
    return (mr > 21'd131071) ? 18'sh1FFFF : $signed({1'b0, mr[PosW-2:0]});
  endfunction

  logic [20:0] xr, yr, zr;
  assign xr = 21'((53'(xm_q) + 53'(64'd1 << 31)) >> 32);
  assign zr = 21'((53'(zm_q) + 53'(64'd1 << 31)) >> 32);
  assign yr = 21'((35'(ym_q) + 35'(32'd1 << 15)) >> 16);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      index_error_o <= side_q[Lat-2].err;
      if (side_q[Lat-2].err) begin
        pos_x_o    <= '0;
        pos_y_o    <= '0;
        pos_z_o    <= '0;
        corner_a_o <= '0;
        corner_b_o <= '0;
        corner_c_o <= '0;
        corner_d_o <= '0;
      end else begin
        pos_x_o    <= sat_pos(xn_q, xr);
        pos_y_o    <= sat_pos(yn_q, yr);
        pos_z_o    <= sat_pos(zn_q, zr);
        corner_a_o <= side_q[Lat-2].ca;
        corner_b_o <= side_q[Lat-2].cb;
        corner_c_o <= side_q[Lat-2].cc;
        corner_d_o <= side_q[Lat-2].cd;
      end
    end
  end

endmodule

// File: hw/rtl/tvfg_sincos.sv
// Pipelined Q16 sine/cosine of 2*pi*idx/cnt: divider, octant fold and Taylor series.
module tvfg_sincos (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic [tvfg_pkg::IdxW-1:0]          idx_i,
  input  logic [tvfg_pkg::CntW-1:0]          cnt_i,
  output logic signed [tvfg_pkg::TrigW-1:0]  sin_o,
  output logic signed [tvfg_pkg::TrigW-1:0]  cos_o
);

  localparam int CntW  = tvfg_pkg::CntW;
  localparam int DivN  = tvfg_pkg::DivStages;
  localparam int HS    = tvfg_pkg::HornerSteps;
  localparam int LoW   = tvfg_pkg::RcpLoW;
  localparam int HiW   = tvfg_pkg::RcpW - tvfg_pkg::RcpLoW;
  localparam int PW    = 30 + LoW;

  typedef struct packed {
    logic [CntW-1:0] rem;
    logic [31:0]     quo;
  } div_t;

  typedef struct packed {
    logic [29:0] a;
    logic [29:0] a2;
    logic [1:0]  quad;
    logic        swap;
  } side_t;

  function automatic div_t div_step(input div_t x, input logic [CntW-1:0] cnt);
    div_t        y;
    logic [CntW:0] r2;
    y = x;
    for (int b = 0; b < tvfg_pkg::DivBits; b++) begin
      r2 = {y.rem, 1'b0};
      if (r2 >= {1'b0, cnt}) begin
        y.rem = CntW'(r2 - {1'b0, cnt});
        y.quo = {y.quo[30:0], 1'b1};
      end else begin
        y.rem = r2[CntW-1:0];
        y.quo = {y.quo[30:0], 1'b0};
      end
    end
    return y;
  endfunction

  function automatic logic [29:0] q30_mul(input logic [29:0] x, input logic [30:0] t);
    return 30'((61'(x) * 61'(t)) >> 30);
  endfunction

  function automatic logic [30:0] horner_sub(input logic [PW-1:0] hi, input logic [PW-1:0] lo);
    logic [PW+LoW:0] sum;
    sum = (PW'(0) + (PW+LoW+1)'(hi) << LoW) + (PW+LoW+1)'(lo);
    return 31'(tvfg_pkg::Q30One) - 31'(sum >> tvfg_pkg::RcpShift);
  endfunction

  function automatic logic signed [tvfg_pkg::TrigW-1:0] signed_mag(input logic [16:0] m,
                                                                     input logic       neg);
    return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  // ---- turn fraction: long division, four quotient bits per stage
  div_t div_q [DivN];

  for (genvar g = 0; g < DivN; g++) begin : g_div
    div_t din;
    if (g == 0) begin : g_first
      assign din = '{rem: CntW'(idx_i), quo: '0};
    end else begin : g_next
      assign din = div_q[g-1];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        div_q[g] <= div_step(din, cnt_i);
      end
    end
  end

  logic [31:0] p_q;
  logic [29:0] r_q;
  logic [1:0]  quad_f_q;
  logic        swap_f_q;
  logic [29:0] a_q;
  logic [1:0]  quad_a_q;
  logic        swap_a_q;
  side_t       side_a2_q;

  logic        round_up;
  logic [29:0] w;
  assign round_up = ({1'b0, div_q[DivN-1].rem} + {2'b0, cnt_i[CntW-1:1]}) >= {1'b0, cnt_i};
  assign w        = p_q[29:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q      <= div_q[DivN-1].quo + 32'(round_up);
      quad_f_q <= p_q[31:30];
      swap_f_q <= w > 30'h2000_0000;
      r_q      <= (w > 30'h2000_0000) ? 30'(31'h4000_0000 - 31'(w)) : w;
      a_q      <= 30'((64'(r_q) * 64'(tvfg_pkg::PiQ30) + 64'(tvfg_pkg::Q30One)) >> 31);
      quad_a_q <= quad_f_q;
      swap_a_q <= swap_f_q;
      side_a2_q.a    <= a_q;
      side_a2_q.a2   <= 30'((61'(a_q) * 61'(a_q) + 61'h2000_0000) >> 30);
      side_a2_q.quad <= quad_a_q;
      side_a2_q.swap <= swap_a_q;
    end
  end

  // ---- Horner slots: product, reciprocal partial products, subtract from one
  logic [29:0]   mc_q  [HS];
  logic [PW-1:0] loc_q [HS];
  logic [PW-1:0] hic_q [HS];
  logic [30:0]   tc_q  [HS];
  logic [29:0]   ms_q  [1:HS-1];
  logic [PW-1:0] los_q [1:HS-1];
  logic [PW-1:0] his_q [1:HS-1];
  logic [30:0]   ts_q  [1:HS-1];
  side_t         sh1_q [HS];
  side_t         sh2_q [HS];
  side_t         sh3_q [HS];

  for (genvar k = 0; k < HS; k++) begin : g_slot
    side_t       sin_side;
    logic [30:0] tc_in;
    if (k == 0) begin : g_first
      assign sin_side = side_a2_q;
      assign tc_in    = tvfg_pkg::Q30One;
    end else begin : g_next
      logic [30:0] ts_in;
      assign sin_side = sh3_q[k-1];
      assign tc_in    = tc_q[k-1];
      if (k == 1) begin : g_sfirst
        assign ts_in = tvfg_pkg::Q30One;
      end else begin : g_snext
        assign ts_in = ts_q[k-1];
      end
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          ms_q[k]  <= q30_mul(sin_side.a2, ts_in);
          los_q[k] <= PW'(ms_q[k]) * PW'(tvfg_pkg::SIN_RCP[k][LoW-1:0]);
          his_q[k] <= PW'(ms_q[k]) * PW'(tvfg_pkg::SIN_RCP[k][LoW+HiW-1:LoW]);
          ts_q[k]  <= horner_sub(his_q[k], los_q[k]);
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        mc_q[k]  <= q30_mul(sin_side.a2, tc_in);
        loc_q[k] <= PW'(mc_q[k]) * PW'(tvfg_pkg::COS_RCP[k][LoW-1:0]);
        hic_q[k] <= PW'(mc_q[k]) * PW'(tvfg_pkg::COS_RCP[k][LoW+HiW-1:LoW]);
        tc_q[k]  <= horner_sub(hic_q[k], loc_q[k]);
        sh1_q[k] <= sin_side;
        sh2_q[k] <= sh1_q[k];
        sh3_q[k] <= sh2_q[k];
      end
    end
  end

  // ---- final sine product, then octant/quadrant mapping and rounding to Q16
  logic [29:0] s_q;
  logic [30:0] c_q;
  logic [1:0]  quad_s_q;
  logic        swap_s_q;

  logic [30:0] sb, cb;
  logic [16:0] rsb, rcb;
  logic signed [tvfg_pkg::TrigW-1:0] sin_d, cos_d;

  always_comb begin
    sb  = swap_s_q ? c_q : {1'b0, s_q};
    cb  = swap_s_q ? {1'b0, s_q} : c_q;
    rsb = 17'((32'(sb) + 32'd8192) >> 14);
    rcb = 17'((32'(cb) + 32'd8192) >> 14);
    case (quad_s_q)
      2'd0: begin
        sin_d = signed_mag(rsb, 1'b0);
        cos_d = signed_mag(rcb, 1'b0);
      end
      2'd1: begin
        sin_d = signed_mag(rcb, 1'b0);
        cos_d = signed_mag(rsb, 1'b1);
      end
      2'd2: begin
        sin_d = signed_mag(rsb, 1'b1);
        cos_d = signed_mag(rcb, 1'b1);
      end
      default: begin
        sin_d = signed_mag(rcb, 1'b1);
        cos_d = signed_mag(rsb, 1'b0);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q      <= q30_mul(sh3_q[HS-1].a, ts_q[HS-1]);
      c_q      <= tc_q[HS-1];
      quad_s_q <= sh3_q[HS-1].quad;
      swap_s_q <= sh3_q[HS-1].swap;
      sin_o    <= sin_d;
      cos_o    <= cos_d;
    end
  end

endmodule
